// ===== hdl/argb_pkg.sv =====
// Shared types, constants and rounding helpers for the pixel format converter.
package argb_pkg;

  // Pipeline registers ahead of the output register: one multiply, one setup, eight quotient steps
  localparam int NSTG = 10;
  localparam int QSTEPS = 8;
  localparam int REM_W = 34;
  localparam int DIV_W = 26;
  // 65535^2 / 255, the rounding offset, and twice that, the 16-bit gray-alpha divisor
  localparam logic [REM_W-1:0] WIDE_D = 34'd16842495;
  localparam logic [DIV_W-1:0] WIDE_2D = 26'd33684990;

  typedef enum logic [2:0] {
    MODE_RGB_BGRX  = 3'd0,
    MODE_SWAP_RB   = 3'd1,
    MODE_UNPREM    = 3'd2,
    MODE_PREM      = 3'd3,
    MODE_GRAYA8    = 3'd4,
    MODE_GRAY8     = 3'd5,
    MODE_GRAY16    = 3'd6,
    MODE_GRAYA16   = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
    logic [7:0] e3;
    logic [7:0] g6;
    logic [7:0] a7;
    logic       last;
  } side_t;

  // x/255 rounded, for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, x} + 17'd128;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

  // w/257 rounded, for any 16-bit w
  function automatic logic [7:0] div257(input logic [15:0] w);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, w} + 17'd128;
    s = t - (t >> 8);
    return s[15:8];
  endfunction

endpackage

// ===== hdl/argb_lane.sv =====
// One colour lane: product, rounded divide by 255 and an eight-step pipelined quotient.
module argb_lane (
  input  logic                   clk,
  input  logic [argb_pkg::NSTG-1:0] ld,
  input  logic [7:0]             in_c,
  input  logic [7:0]             in_a,
  input  logic [15:0]            in_w0,
  input  logic [15:0]            in_w1,
  input  logic                   in_wide,
  output logic [7:0]             out_q,
  output logic [7:0]             out_pm
);

  localparam int QS = argb_pkg::QSTEPS;
  localparam int RW = argb_pkg::REM_W;
  localparam int DW = argb_pkg::DIV_W;

  logic [15:0]   prod8_r;
  logic [31:0]   prod16_r;
  logic [16:0]   n8_r;
  logic [7:0]    a_r;
  logic          wide_r;
  logic [RW-1:0] rem_r [QS+1];
  logic [DW-1:0] dv_r  [QS+1];
  logic [7:0]    pm_r  [QS+1];
  logic [7:0]    q_r   [QS+1];
  logic [16:0]   n8_nxt;

  // Form 2*255*c + a for the unpremultiply quotient
  always_comb begin
    n8_nxt = ({1'b0, in_c, 8'd0} - {9'd0, in_c}) * 17'd2 + {9'd0, in_a};
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod8_r  <= in_c * in_a;
      prod16_r <= in_w0 * in_w1;
      n8_r     <= n8_nxt;
      a_r      <= in_a;
      wide_r   <= in_wide;
    end
  end

  // Setup stage: pick numerator and divisor, finish the divide by 255
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      if (wide_r) begin
        rem_r[0] <= {1'b0, prod16_r, 1'b0} + argb_pkg::WIDE_D;
        dv_r[0]  <= argb_pkg::WIDE_2D;
      end else begin
        rem_r[0] <= {{(RW-17){1'b0}}, n8_r};
        dv_r[0]  <= {{(DW-9){1'b0}}, a_r, 1'b0};
      end
      pm_r[0] <= argb_pkg::div255(prod8_r);
      q_r[0]  <= 8'd0;
    end
  end

  // Restoring quotient steps, most significant bit first
  for (genvar j = 1; j <= QS; j++) begin : g_step
    localparam int K = QS - j;
    logic [RW-1:0] trial;
    logic          take;
    always_comb begin
      trial = {{(RW-DW){1'b0}}, dv_r[j-1]} << K;
      take  = rem_r[j-1] >= trial;
    end
    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        rem_r[j] <= take ? rem_r[j-1] - trial : rem_r[j-1];
        dv_r[j]  <= dv_r[j-1];
        pm_r[j]  <= pm_r[j-1];
        q_r[j]   <= q_r[j-1] | ({7'd0, take} << K);
      end
    end
  end

  assign out_q  = q_r[QS];
  assign out_pm = pm_r[QS];

endmodule

// ===== hdl/argb32_pixel_format_converter_top.sv =====
// One pixel per cycle sustained while out_stall is low; pixels pass the multiply, setup and quotient stages.
// Most of the depth is in the eight one-bit quotient stages of each colour lane.
// A bubble anywhere in the pipeline is closed up, so input continues while a result waits, until the pipeline is full.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets conversion_mode to 0.
// Top level: three colour lanes and the merging output register.
module argb32_pixel_format_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_conversion_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_elem0,
  input  logic [15:0] in_elem1,
  input  logic [7:0]  in_elem2,
  input  logic [7:0]  in_elem3,
  input  logic        in_end_of_run,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic        out_run_last
);

  localparam int NS = argb_pkg::NSTG;

  argb_pkg::mode_t   mode_r;
  argb_pkg::side_t   sb_r [NS];
  argb_pkg::side_t   sb_in;
  logic [NS-1:0]     v_r;
  logic [NS:0]       rdy;
  logic              out_valid_r;
  logic [7:0]        ob0_r, ob1_r, ob2_r, ob3_r;
  logic              olast_r;
  logic [7:0]        ob0_nxt, ob1_nxt, ob2_nxt, ob3_nxt;
  logic [7:0]        lane_c [3];
  logic [7:0]        lane_a;
  logic [7:0]        lane_q [3];
  logic [7:0]        lane_pm [3];
  logic [7:0]        res_c [3];
  logic              is_ga8;
  logic              is_wide;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= argb_pkg::MODE_RGB_BGRX;
    end else if (cfg_valid) begin
      mode_r <= argb_pkg::mode_t'(cfg_conversion_mode);
    end
  end

  // Ready chain: a stage loads when it is empty or its successor moves
  always_comb begin
    rdy[NS] = !out_valid_r || !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign in_stall = !rdy[0];

  // Capture side data and the narrow 16-bit results at entry
  always_comb begin
    sb_in.mode = mode_r;
    sb_in.e0   = in_elem0[7:0];
    sb_in.e1   = in_elem1[7:0];
    sb_in.e2   = in_elem2;
    sb_in.e3   = in_elem3;
    sb_in.g6   = argb_pkg::div257(in_elem0);
    sb_in.a7   = argb_pkg::div257(in_elem1);
    sb_in.last = in_end_of_run;
  end

  // Advance valid bits and side data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sb_r[0] <= sb_in;
    end
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // Lane operands: byte 0 lane takes elem2 (elem0 in GRAYA8 mode), byte 2 lane takes elem0
  always_comb begin
    is_ga8    = mode_r == argb_pkg::MODE_GRAYA8;
    is_wide   = mode_r == argb_pkg::MODE_GRAYA16;
    lane_a    = is_ga8 ? in_elem1[7:0] : in_elem3;
    lane_c[0] = is_ga8 ? in_elem0[7:0] : in_elem2;
    lane_c[1] = is_ga8 ? in_elem0[7:0] : in_elem1[7:0];
    lane_c[2] = in_elem0[7:0];
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    argb_lane u_lane (
      .clk     (clk),
      .ld      (rdy[NS-1:0]),
      .in_c    (lane_c[l]),
      .in_a    (lane_a),
      .in_w0   (in_elem0),
      .in_w1   (in_elem1),
      .in_wide (is_wide),
      .out_q   (lane_q[l]),
      .out_pm  (lane_pm[l])
    );
  end

  // Merge lanes into the destination bytes
  always_comb begin
    argb_pkg::side_t s;
    s = sb_r[NS-1];
    res_c[0] = s.e2;
    res_c[1] = s.e1;
    res_c[2] = s.e0;
    for (int l = 0; l < 3; l++) begin
      if (res_c[l] >= s.e3) begin
        res_c[l] = 8'hff;
      end else begin
        res_c[l] = lane_q[l];
      end
    end
    unique case (s.mode)
      argb_pkg::MODE_RGB_BGRX: begin
        ob0_nxt = s.e2; ob1_nxt = s.e1; ob2_nxt = s.e0; ob3_nxt = 8'hff;
      end
      argb_pkg::MODE_SWAP_RB: begin
        ob0_nxt = s.e2; ob1_nxt = s.e1; ob2_nxt = s.e0; ob3_nxt = s.e3;
      end
      argb_pkg::MODE_UNPREM: begin
        priority if (s.e3 == 8'd0) begin
          ob0_nxt = 8'd0; ob1_nxt = 8'd0; ob2_nxt = 8'd0; ob3_nxt = 8'd0;
        end else if (s.e3 == 8'hff) begin
          ob0_nxt = s.e2; ob1_nxt = s.e1; ob2_nxt = s.e0; ob3_nxt = s.e3;
        end else begin
          ob0_nxt = res_c[0]; ob1_nxt = res_c[1]; ob2_nxt = res_c[2]; ob3_nxt = s.e3;
        end
      end
      argb_pkg::MODE_PREM: begin
        ob0_nxt = lane_pm[0]; ob1_nxt = lane_pm[1]; ob2_nxt = lane_pm[2];
        ob3_nxt = s.e3;
      end
      argb_pkg::MODE_GRAYA8: begin
        ob0_nxt = lane_pm[0]; ob1_nxt = lane_pm[0]; ob2_nxt = lane_pm[0];
        ob3_nxt = s.e1;
      end
      argb_pkg::MODE_GRAY8: begin
        ob0_nxt = s.e0; ob1_nxt = s.e0; ob2_nxt = s.e0; ob3_nxt = 8'hff;
      end
      argb_pkg::MODE_GRAY16: begin
        ob0_nxt = s.g6; ob1_nxt = s.g6; ob2_nxt = s.g6; ob3_nxt = 8'hff;
      end
      argb_pkg::MODE_GRAYA16: begin
        ob0_nxt = lane_q[0]; ob1_nxt = lane_q[0]; ob2_nxt = lane_q[0];
        ob3_nxt = s.a7;
      end
      default: begin
        ob0_nxt = 8'd0; ob1_nxt = 8'd0; ob2_nxt = 8'd0; ob3_nxt = 8'd0;
      end
    endcase
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NS]) begin
      out_valid_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      ob0_r   <= ob0_nxt;
      ob1_r   <= ob1_nxt;
      ob2_r   <= ob2_nxt;
      ob3_r   <= ob3_nxt;
      olast_r <= sb_r[NS-1].last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte0    = ob0_r;
  assign out_byte1    = ob1_r;
  assign out_byte2    = ob2_r;
  assign out_byte3    = ob3_r;
  assign out_run_last = olast_r;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !v_r[NS-1]) |=> !out_valid_r)
    else $error("result request without a pixel behind it");

  a_unprem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy[NS] && v_r[NS-1] && sb_r[NS-1].mode == argb_pkg::MODE_UNPREM
     && sb_r[NS-1].e3 == 8'd0) |=> (out_byte0 == 8'd0 && out_byte3 == 8'd0))
    else $error("zero alpha unpremultiply gave non-zero bytes");
`endif

endmodule
